>>> rtl/core/lst_pkg.sv
// Shared types and constants for the latency statistics table.
// Used by lst_front, lst_back and latency_stats_table_core; no dependencies.
package lst_pkg;

    // Raw operation codes carried on the input tuser
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int SLOT_W    = 6;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 63;
    localparam int TRIM_W    = 64;
    localparam int EXTREME_W = TIME_W + 2;   // four 32-bit values added

    // Epoch tag stored with each entry; a slot is valid when its tag matches
    localparam int EPOCH_W = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        KIND_RECORD,
        KIND_QUERY,
        KIND_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                in_range;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   elapsed;
    } cmd_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]  tag;
        logic [TIME_W-1:0]   count;
        logic [SUM_W-1:0]    sum;
        logic [TIME_W-1:0]   lo1;
        logic [TIME_W-1:0]   lo0;
        logic [TIME_W-1:0]   hi1;
        logic [TIME_W-1:0]   hi0;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0]         max_time;
        logic [TIME_W-1:0]         min_time;
        logic signed [TRIM_W-1:0]  trimmed_total;
        logic [SUM_W-1:0]          total_time;
        logic [TIME_W-1:0]         call_count;
    } result_t;

endpackage

>>> rtl/core/lst_front.sv
// Front part of the latency statistics table: accepts input items, classifies
// them and holds them in a short queue for the back part. Depends on lst_pkg.
module lst_front
    import lst_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         operation,
    input  logic [SLOT_W-1:0]  slot_index,
    input  logic [TIME_W-1:0]  elapsed_time,
    output logic               q_valid,
    input  logic               q_ready,
    output cmd_t               q_cmd
);

    cmd_t                queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;
    cmd_t                cmd_in;

    // Classify: unused code behaves as a query
    always_comb
    begin
        cmd_in.slot     = slot_index;
        cmd_in.elapsed  = elapsed_time;
        cmd_in.in_range = (32'(slot_index) < 32'(SLOT_COUNT));
        priority if (operation == OP_RECORD)
            cmd_in.kind = KIND_RECORD;
        else if (operation == OP_CLEAR)
            cmd_in.kind = KIND_CLEAR;
        else
            cmd_in.kind = KIND_QUERY;
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

>>> rtl/core/lst_back.sv
// Back part of the latency statistics table: slot memory, update and report
// sequencer, and the result register. Depends on lst_pkg.
module lst_back
    import lst_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_ready,
    input  cmd_t     q_cmd,
    output logic     m_tvalid,
    input  logic     m_tready,
    output result_t  m_result
);

    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [TIME_W-1:0] TIME_ONES = '1;
    localparam logic [SUM_W-1:0]  SUM_ONES  = '1;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_UPDATE,
        ST_SUMS,
        ST_REPORT
    } state_t;

    state_t                 state_reg, state_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [ADDR_W-1:0]      sweep_cnt_reg, sweep_cnt_next;
    logic                   sweep_pend_reg, sweep_pend_next;
    cmd_t                   cmd_reg, cmd_next;
    entry_t                 view_reg, view_next;
    logic                   show_reg, show_next;
    logic [EXTREME_W-1:0]   ext_sum_reg, ext_sum_next;
    logic [TIME_W-1:0]      min_reg, min_next;
    logic [TIME_W-1:0]      max_reg, max_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_data_reg, out_data_next;

    entry_t                 slot_mem [SLOT_COUNT];
    entry_t                 rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;

    logic [ADDR_W+SLOT_W-1:0] q_slot_wide, cmd_slot_wide;
    logic                   hit;
    entry_t                 cur, upd, empty_entry;
    logic [TRIM_W-1:0]      sum_wide;
    logic [TIME_W-1:0]      lo0_v, lo1_v;

    assign q_slot_wide   = (ADDR_W+SLOT_W)'(q_cmd.slot);
    assign cmd_slot_wide = (ADDR_W+SLOT_W)'(cmd_reg.slot);
    assign rd_addr       = q_slot_wide[ADDR_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_result = out_data_reg;

    // Current slot contents and the record update
    always_comb
    begin
        empty_entry       = '0;
        empty_entry.lo0   = TIME_ONES;
        empty_entry.lo1   = TIME_ONES;
        empty_entry.tag   = epoch_reg;
        hit = cmd_reg.in_range && (rd_data_reg.tag == epoch_reg);
        cur = hit ? rd_data_reg : empty_entry;

        upd       = cur;
        upd.tag   = epoch_reg;
        upd.count = (cur.count == TIME_ONES) ? cur.count : cur.count + 1'b1;
        sum_wide  = {1'b0, cur.sum} + TRIM_W'(cmd_reg.elapsed);
        upd.sum   = sum_wide[TRIM_W-1] ? SUM_ONES : sum_wide[SUM_W-1:0];
        priority if (cur.lo0 > cmd_reg.elapsed)
        begin
            upd.lo1 = cur.lo0;
            upd.lo0 = cmd_reg.elapsed;
        end
        else if (cur.lo1 > cmd_reg.elapsed)
            upd.lo1 = cmd_reg.elapsed;
        else
            upd.lo1 = cur.lo1;
        priority if (cur.hi0 < cmd_reg.elapsed)
        begin
            upd.hi1 = cur.hi0;
            upd.hi0 = cmd_reg.elapsed;
        end
        else if (cur.hi1 < cmd_reg.elapsed)
            upd.hi1 = cmd_reg.elapsed;
        else
            upd.hi1 = cur.hi1;
    end

    // Unset minima read as zero
    assign lo0_v = (view_reg.lo0 == TIME_ONES) ? '0 : view_reg.lo0;
    assign lo1_v = (view_reg.lo1 == TIME_ONES) ? '0 : view_reg.lo1;

    always_comb
    begin
        state_next      = state_reg;
        epoch_next      = epoch_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_pend_next = sweep_pend_reg;
        cmd_next        = cmd_reg;
        view_next       = view_reg;
        show_next       = show_reg;
        ext_sum_next    = ext_sum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        q_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = sweep_cnt_reg;
        mem_wdata       = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                // tag zero never matches a live epoch
                mem_we = 1'b1;
                if (sweep_cnt_reg == ADDR_W'(SLOT_COUNT - 1))
                begin
                    sweep_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_ready    = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                view_next = cur;
                show_next = hit;
                unique case (cmd_reg.kind)
                    KIND_RECORD:
                    begin
                        if (cmd_reg.in_range)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cmd_slot_wide[ADDR_W-1:0];
                            mem_wdata = upd;
                            view_next = upd;
                            show_next = 1'b1;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        show_next = 1'b0;
                        // on wrap, sweep the tags before the epoch repeats
                        if (epoch_reg == '1)
                        begin
                            epoch_next      = EPOCH_W'(1);
                            sweep_pend_next = 1'b1;
                        end
                        else
                            epoch_next = epoch_reg + 1'b1;
                    end
                    default: ;
                endcase
                state_next = ST_SUMS;
            end
            ST_SUMS:
            begin
                if (show_reg)
                begin
                    ext_sum_next = EXTREME_W'(view_reg.hi0) + EXTREME_W'(view_reg.hi1)
                                 + EXTREME_W'(lo0_v) + EXTREME_W'(lo1_v);
                    min_next = (lo0_v == '0) ? lo1_v : lo0_v;
                    max_next = (view_reg.hi0 == '0) ? view_reg.hi1 : view_reg.hi0;
                end
                else
                begin
                    ext_sum_next = '0;
                    min_next     = '0;
                    max_next     = '0;
                end
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.call_count   = show_reg ? view_reg.count : '0;
                    out_data_next.total_time   = show_reg ? view_reg.sum : '0;
                    out_data_next.trimmed_total =
                        (show_reg ? TRIM_W'(view_reg.sum) : '0) - TRIM_W'(ext_sum_reg);
                    out_data_next.min_time     = min_reg;
                    out_data_next.max_time     = max_reg;
                    sweep_pend_next            = 1'b0;
                    state_next = sweep_pend_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            epoch_reg      <= EPOCH_W'(1);
            sweep_cnt_reg  <= '0;
            sweep_pend_reg <= 1'b0;
            cmd_reg        <= '0;
            view_reg       <= '0;
            show_reg       <= 1'b0;
            ext_sum_reg    <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            epoch_reg      <= epoch_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_pend_reg <= sweep_pend_next;
            cmd_reg        <= cmd_next;
            view_reg       <= view_next;
            show_reg       <= show_next;
            ext_sum_reg    <= ext_sum_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        if (q_ready)
            rd_data_reg <= slot_mem[rd_addr];
    end

`ifndef SYNTH
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> state_reg == ST_IDLE)
        else $error("queue popped outside idle");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch equals the swept tag");

    a_write_record: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg != ST_SWEEP |->
            cmd_reg.in_range && cmd_reg.kind == KIND_RECORD)
        else $error("slot write without an in-range record");

    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT && out_valid_reg && !m_tready |=> state_reg == ST_REPORT)
        else $error("result dropped while output stalled");
`endif

endmodule

>>> rtl/core/latency_stats_table_core.sv
// Latency statistics table: per-slot call count, saturating total, two minima
// and two maxima, queried with a trimmed total. Items enter a two-entry queue
// and the back part handles one at a time (slot memory read, update and
// write-back, extremes sum, report), taking no new item until the result of
// the one before is in the output register; the slot memory has a registered
// read. Clear takes effect by bumping an epoch tag; after reset and after every
// 15th clear a clearing pass rewrites the tag of every slot, during which no
// item leaves the queue. Depends on lst_pkg, lst_front and lst_back.
module latency_stats_table_core
    import lst_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,   // slot_index[5:0], elapsed_time[37:6], zero pad
    input  logic [1:0]    s_tuser,   // operation[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [223:0]  m_tdata    // call_count, total_time, trimmed_total,
                                     // min_time, max_time, zero pad
);

    logic     q_valid;
    logic     q_ready;
    cmd_t     q_cmd;
    result_t  result;

    lst_front #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .operation    (s_tuser),
        .slot_index   (s_tdata[5:0]),
        .elapsed_time (s_tdata[37:6]),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_cmd        (q_cmd)
    );

    lst_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {1'b0, result};

endmodule
